/* hw/rtl/ale_pkg.sv */
// Shared types and constants for the array list engine.
`timescale 1ns / 1ps
`default_nettype none

package ale_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int OPC_W   = 3;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  typedef enum logic [OPC_W-1:0] {
    OP_APPEND = 3'd0,
    OP_DROP   = 3'd1,
    OP_READ   = 3'd2,
    OP_INSERT = 3'd3,
    OP_REMOVE = 3'd4
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;  // capture the input beat
    logic exec;  // perform the operation and latch its result
  } ale_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/ale_ctrl.sv */
// Controller state machine: sequences capture, execute and result handoff.
`timescale 1ns / 1ps
`default_nettype none

module ale_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire              out_tready,
  output ale_pkg::ale_cmd_t cmd
);
  import ale_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign cmd.load   = in_tvalid && (state_r == S_IDLE);
  assign cmd.exec   = (state_r == S_EXEC) && out_free;

  // a new result wins over the handoff of the old one in the same cycle
  assign out_valid_nxt = cmd.exec ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ale_datapath.sv */
// Datapath: entry cell chain, element count and result registers.
`timescale 1ns / 1ps
`default_nettype none

module ale_datapath #(
  parameter int CAPACITY = ale_pkg::CAPACITY_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  ale_pkg::ale_cmd_t                 cmd,
  input  wire        [ale_pkg::OPC_W-1:0]   opcode,
  input  wire        [ale_pkg::POS_W-1:0]   position,
  input  wire signed [ale_pkg::VAL_W-1:0]   item_value,
  output logic signed [ale_pkg::VAL_W-1:0]  read_value,
  output logic        [ale_pkg::STAT_W-1:0] status,
  output logic        [ale_pkg::COUNT_W-1:0] element_count
);
  import ale_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic        [OPC_W-1:0] op_r;
  logic        [POS_W-1:0] pos_r;
  logic signed [VAL_W-1:0] val_r;

  logic        [VAL_W-1:0] cells_r [CAPACITY];
  logic        [CNT_W-1:0] count_r;
  logic        [CNT_W-1:0] count_nxt;
  logic signed [VAL_W-1:0] rd_r;
  logic signed [VAL_W-1:0] rd_nxt;
  logic       [STAT_W-1:0] st_r;
  logic       [STAT_W-1:0] st_nxt;

  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;
  logic             is_full;
  logic             do_append;
  logic             do_insert;
  logic             do_remove;

  assign pos_c   = CMP_W'(pos_r);
  assign cnt_c   = CMP_W'(count_r);
  assign is_full = (cnt_c == CMP_W'(CAPACITY));

  always_comb begin
    count_nxt = count_r;
    rd_nxt    = '0;
    st_nxt    = ST_OK;
    do_append = 1'b0;
    do_insert = 1'b0;
    do_remove = 1'b0;
    case (op_r)
      OP_APPEND: begin
        if (is_full) begin
          st_nxt = ST_FULL;
        end else begin
          do_append = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DROP: begin
        if (count_r == '0) begin
          st_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (pos_c >= cnt_c) begin
          st_nxt = ST_RANGE;
        end else begin
          rd_nxt = cells_r[pos_c[IDX_W-1:0]];
        end
      end
      OP_INSERT: begin
        if (pos_c > cnt_c) begin
          st_nxt = ST_RANGE;
        end else if (is_full) begin
          st_nxt = ST_FULL;
        end else begin
          do_insert = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_c >= cnt_c) begin
          st_nxt = ST_RANGE;
        end else begin
          do_remove = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= opcode;
      pos_r <= position;
      val_r <= item_value;
    end
  end

  // each cell looks only at its two neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CMP_W-1:0] ME = CMP_W'(i);
    localparam logic [CMP_W-1:0] ME_UP = CMP_W'(i + 1);
    logic [VAL_W-1:0] below;
    logic [VAL_W-1:0] above;
    if (i == 0) begin : g_lo
      assign below = cells_r[i];
    end else begin : g_lo
      assign below = cells_r[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign above = cells_r[i];
    end else begin : g_hi
      assign above = cells_r[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (do_append && (ME == cnt_c)) begin
          cells_r[i] <= val_r;
        end else if (do_insert && (ME == pos_c)) begin
          cells_r[i] <= val_r;
        end else if (do_insert && (ME > pos_c) && (ME <= cnt_c)) begin
          cells_r[i] <= below;
        end else if (do_remove && (ME >= pos_c) && (ME_UP < cnt_c)) begin
          cells_r[i] <= above;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_r <= rd_nxt;
      st_r <= st_nxt;
    end
  end

  assign read_value    = rd_r;
  assign status        = st_r;
  assign element_count = COUNT_W'(count_r);

endmodule

`default_nettype wire

/* hw/rtl/array_list_engine_top.sv */
// Top level of the array list engine: stream ports, controller and datapath.
// Each input beat is captured, then executed; the result is registered.
// The controller takes no new input beat until the last one has executed;
//   execution holds while the result register is occupied.
// The next input beat is taken while a finished result still waits.
// Reset (rst_n, synchronous, active low) empties the list and drops any
//   pending result; entry cells keep no reset value.
`timescale 1ns / 1ps
`default_nettype none

module array_list_engine_top #(
  parameter int CAPACITY = ale_pkg::CAPACITY_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // input channel
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,   // [4:0] position, [36:5] item_value, [39:37] unused
  input  wire  [2:0]  in_tuser,   // [2:0] opcode
  // result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // [31:0] read_value, [36:32] element_count, [39:37] zero
  output logic [1:0]  out_tuser   // [1:0] status
);
  import ale_pkg::*;

  ale_cmd_t cmd;

  logic signed [VAL_W-1:0]   read_value;
  logic        [COUNT_W-1:0] element_count;

  ale_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ale_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .opcode        (in_tuser),
    .position      (in_tdata[4:0]),
    .item_value    (in_tdata[36:5]),
    .read_value    (read_value),
    .status        (out_tuser),
    .element_count (element_count)
  );

  // pack the result beat; upper pad bits stay zero
  assign out_tdata = {3'b000, element_count, read_value};

endmodule

`default_nettype wire
